// ===== src/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, held off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/irpwd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package irpwd_pkg;

  // Field widths.
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CodeW  = 32;
  localparam int unsigned BoundW = 16;
  localparam int unsigned KeyW   = 2;
  localparam int unsigned CfgIdxW = 4;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_LEADER_PULSE_MIN = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_LEADER_PULSE_MAX = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_LEADER_SPACE_MIN = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_LEADER_SPACE_MAX = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_SHORT_MIN        = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_SHORT_MAX        = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_LONG_MIN         = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_LONG_MAX         = 4'd7;

  // Reset values of the timing windows, in microseconds.
  localparam logic [BoundW-1:0] RST_LEADER_PULSE_MIN = 16'd8500;
  localparam logic [BoundW-1:0] RST_LEADER_PULSE_MAX = 16'd9500;
  localparam logic [BoundW-1:0] RST_LEADER_SPACE_MIN = 16'd4000;
  localparam logic [BoundW-1:0] RST_LEADER_SPACE_MAX = 16'd5000;
  localparam logic [BoundW-1:0] RST_SHORT_MIN        = 16'd510;
  localparam logic [BoundW-1:0] RST_SHORT_MAX        = 16'd610;
  localparam logic [BoundW-1:0] RST_LONG_MIN         = 16'd1580;
  localparam logic [BoundW-1:0] RST_LONG_MAX         = 16'd1780;

  // Known key codes and their report values.
  localparam logic [CodeW-1:0] CODE_VOL_DOWN = 32'h4BB6C03F;
  localparam logic [CodeW-1:0] CODE_VOL_UP   = 32'h4BB640BF;
  localparam logic [CodeW-1:0] CODE_MUTE     = 32'h4BB6A05F;

  localparam logic [KeyW-1:0] KEY_NONE     = 2'd0;
  localparam logic [KeyW-1:0] KEY_VOL_DOWN = 2'd1;
  localparam logic [KeyW-1:0] KEY_VOL_UP   = 2'd2;
  localparam logic [KeyW-1:0] KEY_MUTE     = 2'd3;

  // Timing window bounds handed from the register file to the decoder.
  typedef struct packed {
    logic [BoundW-1:0] leader_pulse_min;
    logic [BoundW-1:0] leader_pulse_max;
    logic [BoundW-1:0] leader_space_min;
    logic [BoundW-1:0] leader_space_max;
    logic [BoundW-1:0] short_min;
    logic [BoundW-1:0] short_max;
    logic [BoundW-1:0] long_min;
    logic [BoundW-1:0] long_max;
  } irpwd_win_t;

  // A duration lies strictly between lo and hi; a negative duration never does.
  // Since hi fits in 16 bits, any match has the upper duration bits all zero.
  function automatic logic in_window(input logic [TimeW-1:0] dur,
                                     input logic [BoundW-1:0] lo,
                                     input logic [BoundW-1:0] hi);
    logic upper_zero;
    upper_zero = (dur[TimeW-1:BoundW] == '0);
    return upper_zero && (dur[BoundW-1:0] > lo) && (dur[BoundW-1:0] < hi);
  endfunction

endpackage

`default_nettype wire

// ===== src/ir_pulse_width_decoder.sv =====
// IR pulse-width decoder for NEC-style remote control frames.
// Input stream (in_*): one transaction per line edge or frame end. in_tuser is
// the command (0 = line edge, 1 = frame end); in_tdata carries the edge's
// microsecond timestamp and the line level read just after it.
// Output stream (out_*): one transaction per frame end, carrying the 32-bit code
// (first received bit most significant) and the matched key (0 none,
// 1 volume down, 2 volume up, 3 mute). Line edges produce no output.
// Configuration (cfg_*): eight 16-bit exclusive window bounds, indexes 0 to 7;
// other indexes are ignored. cfg_ready is always high; write only while idle.
// Timing: an accepted transaction is registered, decoded from the input register
// and a frame end's report is registered for out_*. One transaction is accepted per
// cycle unless a frame end is stalled; the decode is a single subtract and a few
// compares between the input register and the state/result registers.
// Reset clears the decoder state and reloads the standard NEC windows.
// When the receiver stalls, a frame report waits in the output register while
// line edges keep flowing; a second frame end waits in the input register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ir_pulse_width_decoder
  import irpwd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Input stream: tdata = {pad, line_level[32], edge_time[31:0]}; tuser = command.
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [InDataW-1:0]  in_tdata,
  input  wire logic                in_tuser,
  // Output stream: tdata = {pad, key_match[33:32], code_word[31:0]}.
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata,
  // Configuration write channel.
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [BoundW-1:0]   cfg_data
);

  irpwd_win_t       win;
  logic             st_valid_r, st_valid_nxt;
  logic             st_cmd_r;
  logic [TimeW-1:0] st_time_r;
  logic             st_level_r;
  logic             out_valid_r, out_valid_nxt;
  logic [CodeW-1:0] out_code_r;
  logic [KeyW-1:0]  out_key_r;
  logic [CodeW-1:0] rslt_code;
  logic [KeyW-1:0]  rslt_key;
  logic             out_free;
  logic             advance;
  logic             in_fire;

  assign cfg_ready = 1'b1;

  irpwd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .win      (win)
  );

  // A registered item moves on unless it is a frame end facing a full output.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = st_valid_r && (!st_cmd_r || out_free);
  assign in_tready = !st_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  irpwd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .cmd_end    (st_cmd_r),
    .edge_time  (st_time_r),
    .line_level (st_level_r),
    .win        (win),
    .rslt_code  (rslt_code),
    .rslt_key   (rslt_key)
  );

  // Input register control.
  always_comb begin
    st_valid_nxt = st_valid_r;
    if (in_fire) st_valid_nxt = 1'b1;
    else if (advance) st_valid_nxt = 1'b0;
  end

  // Output register control.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && st_cmd_r) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_valid_r  <= st_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      st_cmd_r   <= in_tuser;
      st_time_r  <= in_tdata[TimeW-1:0];
      st_level_r <= in_tdata[TimeW];
    end
    if (advance && st_cmd_r) begin
      out_code_r <= rslt_code;
      out_key_r  <= rslt_key;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - CodeW - KeyW){1'b0}}, out_key_r, out_code_r};

  `ASSERT_CLK(a_end_reports, (advance && st_cmd_r) |=> out_tvalid, "frame end produced no report")
  `ASSERT_CLK(a_stall_holds_item, (st_valid_r && !advance) |=> st_valid_r, "stalled item was lost")
  `ASSERT_ALWAYS(a_ready_when_empty, (rst_n && !st_valid_r) |-> in_tready, "input stalled with an empty input register")

endmodule

`default_nettype wire

// ===== src/irpwd_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module irpwd_cfg
  import irpwd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire logic [CfgIdxW-1:0] wr_index,
  input  wire logic [BoundW-1:0]  wr_data,
  output irpwd_win_t              win
);

  irpwd_win_t win_r;
  irpwd_win_t win_nxt;

  // Decode the register index; indexes past the list are dropped.
  always_comb begin
    win_nxt = win_r;
    if (wr_en) begin
      case (wr_index)
        REG_LEADER_PULSE_MIN: win_nxt.leader_pulse_min = wr_data;
        REG_LEADER_PULSE_MAX: win_nxt.leader_pulse_max = wr_data;
        REG_LEADER_SPACE_MIN: win_nxt.leader_space_min = wr_data;
        REG_LEADER_SPACE_MAX: win_nxt.leader_space_max = wr_data;
        REG_SHORT_MIN:        win_nxt.short_min        = wr_data;
        REG_SHORT_MAX:        win_nxt.short_max        = wr_data;
        REG_LONG_MIN:         win_nxt.long_min         = wr_data;
        REG_LONG_MAX:         win_nxt.long_max         = wr_data;
        default: begin
        end
      endcase
    end
  end

  // Bounds come up at the standard NEC timing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.leader_pulse_min <= RST_LEADER_PULSE_MIN;
      win_r.leader_pulse_max <= RST_LEADER_PULSE_MAX;
      win_r.leader_space_min <= RST_LEADER_SPACE_MIN;
      win_r.leader_space_max <= RST_LEADER_SPACE_MAX;
      win_r.short_min        <= RST_SHORT_MIN;
      win_r.short_max        <= RST_SHORT_MAX;
      win_r.long_min         <= RST_LONG_MIN;
      win_r.long_max         <= RST_LONG_MAX;
    end else begin
      win_r <= win_nxt;
    end
  end

  assign win = win_r;

endmodule

`default_nettype wire

// ===== src/irpwd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module irpwd_core
  import irpwd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic             cmd_end,
  input  wire logic [TimeW-1:0] edge_time,
  input  wire logic             line_level,
  input  wire irpwd_win_t       win,
  output logic [CodeW-1:0]      rslt_code,
  output logic [KeyW-1:0]       rslt_key
);

  typedef enum logic [1:0] {
    PH_LEADER_PULSE,
    PH_LEADER_SPACE,
    PH_BIT_PULSE,
    PH_BIT_SPACE
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [TimeW-1:0] last_time_r, last_time_nxt;
  logic             have_ref_r, have_ref_nxt;
  logic             halted_r, halted_nxt;
  logic [CodeW-1:0] shift_code_r, shift_code_nxt;
  logic [TimeW-1:0] dur;
  logic             win_lp, win_ls, win_short, win_long;

  // Duration since the previous edge, wrapping.
  assign dur = edge_time - last_time_r;

  assign win_lp    = in_window(dur, win.leader_pulse_min, win.leader_pulse_max);
  assign win_ls    = in_window(dur, win.leader_space_min, win.leader_space_max);
  assign win_short = in_window(dur, win.short_min, win.short_max);
  assign win_long  = in_window(dur, win.long_min, win.long_max);

  // Phase machine: advance on a matching edge, freeze on the first mismatch.
  always_comb begin
    phase_nxt      = phase_r;
    last_time_nxt  = last_time_r;
    have_ref_nxt   = have_ref_r;
    halted_nxt     = halted_r;
    shift_code_nxt = shift_code_r;
    if (fire) begin
      if (cmd_end) begin
        phase_nxt      = PH_LEADER_PULSE;
        last_time_nxt  = '0;
        have_ref_nxt   = 1'b0;
        halted_nxt     = 1'b0;
        shift_code_nxt = '0;
      end else if (!have_ref_r) begin
        last_time_nxt = edge_time;
        have_ref_nxt  = 1'b1;
      end else begin
        last_time_nxt = edge_time;
        if (!halted_r) begin
          case (phase_r)
            PH_LEADER_PULSE: begin
              if (line_level && win_lp) phase_nxt = PH_LEADER_SPACE;
              else halted_nxt = 1'b1;
            end
            PH_LEADER_SPACE: begin
              if (!line_level && win_ls) phase_nxt = PH_BIT_PULSE;
              else halted_nxt = 1'b1;
            end
            PH_BIT_PULSE: begin
              if (line_level && win_short) phase_nxt = PH_BIT_SPACE;
              else halted_nxt = 1'b1;
            end
            default: begin
              // The short window wins where the two overlap.
              if (!line_level && win_short) begin
                shift_code_nxt = {shift_code_r[CodeW-2:0], 1'b0};
                phase_nxt      = PH_BIT_PULSE;
              end else if (!line_level && win_long) begin
                shift_code_nxt = {shift_code_r[CodeW-2:0], 1'b1};
                phase_nxt      = PH_BIT_PULSE;
              end else begin
                halted_nxt = 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEADER_PULSE;
      last_time_r  <= '0;
      have_ref_r   <= 1'b0;
      halted_r     <= 1'b0;
      shift_code_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      last_time_r  <= last_time_nxt;
      have_ref_r   <= have_ref_nxt;
      halted_r     <= halted_nxt;
      shift_code_r <= shift_code_nxt;
    end
  end

  // Frame report built from the code held before the frame end clears it.
  assign rslt_code = shift_code_r;

  always_comb begin
    if (shift_code_r == CODE_VOL_DOWN) rslt_key = KEY_VOL_DOWN;
    else if (shift_code_r == CODE_VOL_UP) rslt_key = KEY_VOL_UP;
    else if (shift_code_r == CODE_MUTE) rslt_key = KEY_MUTE;
    else rslt_key = KEY_NONE;
  end

  `ASSERT_CLK(a_halt_freezes, (halted_r && !(fire && cmd_end)) |=> ($stable(phase_r) && $stable(shift_code_r) && halted_r), "halted decoder changed its code or phase")
  `ASSERT_CLK(a_end_clears, (fire && cmd_end) |=> (!have_ref_r && !halted_r && shift_code_r == '0), "frame end did not clear the decoder")
  `ASSERT_CLK(a_ref_first, (!have_ref_r) |-> (phase_r == PH_LEADER_PULSE && !halted_r), "decoder left its first phase without a reference edge")

endmodule

`default_nettype wire

// ===== test/ir_pulse_width_decoder_tb.sv =====
`timescale 1ns / 1ps

module ir_pulse_width_decoder_tb;
  import irpwd_pkg::*;

  // Item kinds carried on in_tuser, and the line levels of mark and space.
  localparam logic CMD_EDGE      = 1'b0;
  localparam logic CMD_FRAME_END = 1'b1;
  localparam logic LEVEL_MARK    = 1'b1;
  localparam logic LEVEL_SPACE   = 1'b0;

  // Indexes past the last window register are ignored by the block.
  localparam logic [CfgIdxW-1:0] REG_FIRST_UNUSED = REG_LONG_MAX + 1'b1;

  // Cycles to let pass after the last report before a register write or the end.
  localparam int DRAIN_CYCLES = 4;
  // Cycles without any transaction after which the run is declared hung.
  localparam int STALL_LIMIT  = 2000;

  typedef enum logic [1:0] {LEAD_MARK, LEAD_GAP, BIT_MARK, BIT_GAP} rx_phase_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [KeyW-1:0]  key;
  } frame_report_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [BoundW-1:0]   cfg_data;

  // Decoder state mirrored by the testbench.
  irpwd_win_t       bounds;
  logic [TimeW-1:0] prev_time = '0;
  logic             have_ref = 1'b0;
  rx_phase_t        rx_phase = LEAD_MARK;
  logic             halted = 1'b0;
  logic [CodeW-1:0] code_sr = '0;

  frame_report_t    frame_reports[$];
  logic [TimeW-1:0] now;
  logic             idle_on;
  int               err_count = 0;
  int               items_sent = 0;
  int               reports_made = 0;
  int               quiet_cycles = 0;

  ir_pulse_width_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Standard NEC timing windows, as loaded by reset.
  function automatic irpwd_win_t nec_windows();
    irpwd_win_t w;
    w.leader_pulse_min = RST_LEADER_PULSE_MIN;
    w.leader_pulse_max = RST_LEADER_PULSE_MAX;
    w.leader_space_min = RST_LEADER_SPACE_MIN;
    w.leader_space_max = RST_LEADER_SPACE_MAX;
    w.short_min        = RST_SHORT_MIN;
    w.short_max        = RST_SHORT_MAX;
    w.long_min         = RST_LONG_MIN;
    w.long_max         = RST_LONG_MAX;
    return w;
  endfunction

  // A duration matches when it is non-negative and strictly between lo and hi.
  function automatic logic fits(input logic [TimeW-1:0] dur, input logic [BoundW-1:0] lo,
                                input logic [BoundW-1:0] hi);
    return !dur[TimeW-1] && (dur > {16'b0, lo}) && (dur < {16'b0, hi});
  endfunction

  // Advance the mirrored decoder by one accepted item; a frame end queues a report.
  function automatic void decode_item(input logic cmd, input logic [TimeW-1:0] t,
                                      input logic lvl);
    logic [TimeW-1:0] dur;
    frame_report_t    rep;
    dur = t - prev_time;
    if (cmd == CMD_FRAME_END) begin
      rep.code = code_sr;
      case (code_sr)
        CODE_VOL_DOWN: rep.key = KEY_VOL_DOWN;
        CODE_VOL_UP:   rep.key = KEY_VOL_UP;
        CODE_MUTE:     rep.key = KEY_MUTE;
        default:       rep.key = KEY_NONE;
      endcase
      frame_reports.push_back(rep);
      reports_made++;
      prev_time = '0;
      have_ref  = 1'b0;
      rx_phase  = LEAD_MARK;
      halted    = 1'b0;
      code_sr   = '0;
    end else if (!have_ref) begin
      prev_time = t;
      have_ref  = 1'b1;
    end else begin
      prev_time = t;
      if (!halted) begin
        case (rx_phase)
          LEAD_MARK: begin
            if (lvl == LEVEL_MARK && fits(dur, bounds.leader_pulse_min, bounds.leader_pulse_max))
              rx_phase = LEAD_GAP;
            else
              halted = 1'b1;
          end
          LEAD_GAP: begin
            if (lvl == LEVEL_SPACE && fits(dur, bounds.leader_space_min, bounds.leader_space_max))
              rx_phase = BIT_MARK;
            else
              halted = 1'b1;
          end
          BIT_MARK: begin
            if (lvl == LEVEL_MARK && fits(dur, bounds.short_min, bounds.short_max))
              rx_phase = BIT_GAP;
            else
              halted = 1'b1;
          end
          default: begin
            // The short window wins when both space windows match.
            if (lvl == LEVEL_SPACE && fits(dur, bounds.short_min, bounds.short_max)) begin
              code_sr  = {code_sr[CodeW-2:0], 1'b0};
              rx_phase = BIT_MARK;
            end else if (lvl == LEVEL_SPACE && fits(dur, bounds.long_min, bounds.long_max)) begin
              code_sr  = {code_sr[CodeW-2:0], 1'b1};
              rx_phase = BIT_MARK;
            end else begin
              halted = 1'b1;
            end
          end
        endcase
      end
    end
  endfunction

  // A random duration inside an open window, or any 16-bit value if the window is empty.
  function automatic logic [TimeW-1:0] pick_dur(input logic [BoundW-1:0] lo,
                                                input logic [BoundW-1:0] hi);
    int l;
    int h;
    l = lo;
    h = hi;
    if (h > l + 1)
      return $urandom_range(h - 1, l + 1);
    return $urandom_range(0, 65535);
  endfunction

  // Send one input transaction; called and returning on a falling edge.
  task automatic send_item(input logic cmd, input logic [TimeW-1:0] t, input logic lvl);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(InDataW-TimeW-1){1'b0}}, lvl, t};
    do @(posedge clk); while (!in_tready);
    decode_item(cmd, t, lvl);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic edge_after(input logic [TimeW-1:0] dur, input logic lvl);
    now = now + dur;
    send_item(CMD_EDGE, now, lvl);
  endtask

  task automatic frame_end();
    send_item(CMD_FRAME_END, $urandom(), $urandom_range(0, 1));
  endtask

  // Drop valid and wait until every report has arrived and the pipeline is empty.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (frame_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One configuration transaction; valid is left high for a following write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [BoundW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LEADER_PULSE_MIN: bounds.leader_pulse_min = val;
      REG_LEADER_PULSE_MAX: bounds.leader_pulse_max = val;
      REG_LEADER_SPACE_MIN: bounds.leader_space_min = val;
      REG_LEADER_SPACE_MAX: bounds.leader_space_max = val;
      REG_SHORT_MIN:        bounds.short_min = val;
      REG_SHORT_MAX:        bounds.short_max = val;
      REG_LONG_MIN:         bounds.long_min = val;
      REG_LONG_MAX:         bounds.long_max = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Load all eight windows, preceded by a write to an unused index.
  task automatic load_windows(input irpwd_win_t w);
    logic [CfgIdxW-1:0] spare_idx;
    spare_idx = $urandom_range(REG_FIRST_UNUSED, (1 << CfgIdxW) - 1);
    wait_idle();
    write_reg(spare_idx, $urandom());
    write_reg(REG_LEADER_PULSE_MIN, w.leader_pulse_min);
    write_reg(REG_LEADER_PULSE_MAX, w.leader_pulse_max);
    write_reg(REG_LEADER_SPACE_MIN, w.leader_space_min);
    write_reg(REG_LEADER_SPACE_MAX, w.leader_space_max);
    write_reg(REG_SHORT_MIN, w.short_min);
    write_reg(REG_SHORT_MAX, w.short_max);
    write_reg(REG_LONG_MIN, w.long_min);
    write_reg(REG_LONG_MAX, w.long_max);
    cfg_valid <= 1'b0;
  endtask

  // Send the edges of one frame: reference, leader, nbits bits of pattern (most
  // significant first) and a closing mark. Edge number bad_at, if any, is spoiled.
  task automatic send_frame(input logic [63:0] pattern, input int nbits, input int bad_at);
    int               n;
    logic [TimeW-1:0] dur;
    logic             lvl;
    n = 2 * nbits + 4;
    now = $urandom();
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        dur = '0;
        lvl = $urandom_range(0, 1);
      end else if (i == 1) begin
        dur = pick_dur(bounds.leader_pulse_min, bounds.leader_pulse_max);
        lvl = LEVEL_MARK;
      end else if (i == 2) begin
        dur = pick_dur(bounds.leader_space_min, bounds.leader_space_max);
        lvl = LEVEL_SPACE;
      end else if (i % 2 == 1) begin
        dur = pick_dur(bounds.short_min, bounds.short_max);
        lvl = LEVEL_MARK;
      end else begin
        if (pattern[nbits - 1 - (i - 4) / 2])
          dur = pick_dur(bounds.long_min, bounds.long_max);
        else
          dur = pick_dur(bounds.short_min, bounds.short_max);
        lvl = LEVEL_SPACE;
      end
      if (i == bad_at) begin
        case ($urandom_range(0, 3))
          0: lvl = ~lvl;
          1: dur = $urandom();
          2: dur = 32'd0 - $urandom_range(1, 2000);
          default: dur = {16'b0, bounds.short_max};
        endcase
      end
      if (i == 0)
        send_item(CMD_EDGE, now, lvl);
      else
        edge_after(dur, lvl);
    end
  endtask

  // Random frames, mostly short and well formed, some spoiled, some pure noise.
  task automatic run_frames(input int item_goal, input int report_goal);
    int          first_item;
    int          first_report;
    int          nbits;
    int          pick;
    int          bad_at;
    logic [63:0] pattern;
    first_item   = items_sent;
    first_report = reports_made;
    while (items_sent - first_item < item_goal || reports_made - first_report < report_goal) begin
      pick    = $urandom_range(0, 19);
      pattern = {$urandom(), $urandom()};
      if (pick == 0) begin
        repeat ($urandom_range(1, 6)) send_item(CMD_EDGE, $urandom(), $urandom_range(0, 1));
        frame_end();
      end else begin
        if (pick <= 13) begin
          nbits = $urandom_range(0, 6);
        end else if (pick <= 16) begin
          nbits = 32;
          case ($urandom_range(0, 3))
            0: pattern[CodeW-1:0] = CODE_VOL_DOWN;
            1: pattern[CodeW-1:0] = CODE_VOL_UP;
            2: pattern[CodeW-1:0] = CODE_MUTE;
            default: ;
          endcase
        end else if (pick == 17) begin
          nbits = $urandom_range(33, 40);
        end else begin
          nbits = $urandom_range(7, 31);
        end
        bad_at = -1;
        if ($urandom_range(0, 3) == 0)
          bad_at = $urandom_range(1, 2 * nbits + 3);
        send_frame(pattern, nbits, bad_at);
        frame_end();
      end
    end
  endtask

  // Frame end with no edges, and with only a reference edge.
  task automatic test_empty_frames();
    frame_end();
    send_item(CMD_EDGE, $urandom(), LEVEL_MARK);
    frame_end();
  endtask

  // A one-bit frame whose leader mark crosses the timestamp wrap.
  task automatic test_counter_wrap();
    now = '1;
    send_item(CMD_EDGE, now, LEVEL_SPACE);
    edge_after(9000, LEVEL_MARK);
    edge_after(4500, LEVEL_SPACE);
    edge_after(560, LEVEL_MARK);
    edge_after(1700, LEVEL_SPACE);
    frame_end();
  endtask

  // A leader mark exactly on its lower bound fails; later edges are ignored.
  task automatic test_window_bounds();
    now = $urandom();
    send_item(CMD_EDGE, now, LEVEL_SPACE);
    edge_after({16'b0, bounds.leader_pulse_min}, LEVEL_MARK);
    edge_after(4500, LEVEL_SPACE);
    frame_end();
  endtask

  // An edge earlier than the reference gives a negative duration and halts.
  task automatic test_negative_duration();
    now = 32'd1000;
    send_item(CMD_EDGE, now, LEVEL_SPACE);
    now = now - 5;
    send_item(CMD_EDGE, now, LEVEL_MARK);
    edge_after(4500, LEVEL_SPACE);
    frame_end();
  endtask

  // Overlapping space windows prefer a zero; an inverted window never matches.
  task automatic test_overlap_and_inverted();
    irpwd_win_t w;
    w = nec_windows();
    w.short_min = 16'd500;
    w.short_max = 16'd700;
    w.long_min  = 16'd600;
    w.long_max  = 16'd1800;
    load_windows(w);
    now = $urandom();
    send_item(CMD_EDGE, now, LEVEL_SPACE);
    edge_after(9000, LEVEL_MARK);
    edge_after(4500, LEVEL_SPACE);
    edge_after(550, LEVEL_MARK);
    edge_after(650, LEVEL_SPACE);
    edge_after(550, LEVEL_MARK);
    edge_after(1000, LEVEL_SPACE);
    frame_end();
    w.short_min = 16'd700;
    w.short_max = 16'd500;
    w.long_min  = 16'd1600;
    w.long_max  = 16'd1600;
    load_windows(w);
    now = $urandom();
    send_item(CMD_EDGE, now, LEVEL_SPACE);
    edge_after(9000, LEVEL_MARK);
    edge_after(4500, LEVEL_SPACE);
    edge_after(600, LEVEL_MARK);
    frame_end();
  endtask

  task automatic test_default_windows();
    load_windows(nec_windows());
    run_frames(90, 2);
  endtask

  // Random windows; short and long may overlap.
  task automatic test_random_windows();
    irpwd_win_t w;
    w.leader_pulse_min = $urandom_range(0, 60000);
    w.leader_pulse_max = w.leader_pulse_min + $urandom_range(2, 5000);
    w.leader_space_min = $urandom_range(0, 60000);
    w.leader_space_max = w.leader_space_min + $urandom_range(2, 5000);
    w.short_min        = $urandom_range(0, 60000);
    w.short_max        = w.short_min + $urandom_range(2, 5000);
    w.long_min         = $urandom_range(0, 60000);
    w.long_max         = w.long_min + $urandom_range(2, 5000);
    load_windows(w);
    run_frames(90, 2);
  endtask

  // Every window as wide as the registers allow.
  task automatic test_widest_windows();
    irpwd_win_t w;
    w.leader_pulse_min = '0;
    w.leader_pulse_max = '1;
    w.leader_space_min = '0;
    w.leader_space_max = '1;
    w.short_min        = '0;
    w.short_max        = '1;
    w.long_min         = '0;
    w.long_max         = '1;
    load_windows(w);
    run_frames(90, 2);
  endtask

  // Every window admits exactly one duration.
  task automatic test_tight_windows();
    irpwd_win_t w;
    w.leader_pulse_min = $urandom_range(0, 65533);
    w.leader_pulse_max = w.leader_pulse_min + 2;
    w.leader_space_min = $urandom_range(0, 65533);
    w.leader_space_max = w.leader_space_min + 2;
    w.short_min        = $urandom_range(0, 65533);
    w.short_max        = w.short_min + 2;
    w.long_min         = $urandom_range(0, 65533);
    w.long_max         = w.long_min + 2;
    load_windows(w);
    run_frames(90, 2);
  endtask

  // Standard windows with both sides running at full rate.
  task automatic test_back_to_back();
    wait_idle();
    idle_on = 1'b0;
    load_windows(nec_windows());
    run_frames(90, 2);
  endtask

  // Receiver readiness: random stalls while idling is on.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each frame report transaction with the oldest expected one.
  always @(posedge clk) begin
    frame_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_reports.size() == 0) begin
        err_count++;
        $display("%0t: unexpected report, expected none, got code %h key %0d", $time,
                 out_tdata[CodeW-1:0], out_tdata[CodeW+KeyW-1:CodeW]);
      end else begin
        want = frame_reports.pop_front();
        if (out_tdata[CodeW-1:0] !== want.code) begin
          err_count++;
          $display("%0t: code_word expected %h, got %h", $time, want.code,
                   out_tdata[CodeW-1:0]);
        end
        if (out_tdata[CodeW+KeyW-1:CodeW] !== want.key) begin
          err_count++;
          $display("%0t: key_match expected %0d, got %0d", $time, want.key,
                   out_tdata[CodeW+KeyW-1:CodeW]);
        end
      end
    end
  end

  // Watchdog: too long without any transaction means the block is hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_EDGE;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_on   = 1'b1;
    now       = '0;
    bounds    = nec_windows();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_frames();
    test_counter_wrap();
    test_window_bounds();
    test_negative_duration();
    test_overlap_and_inverted();
    test_default_windows();
    test_random_windows();
    test_widest_windows();
    test_tight_windows();
    test_back_to_back();

    wait_idle();
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/irpwd_pkg.sv
src/irpwd_cfg.sv
src/irpwd_core.sv
src/ir_pulse_width_decoder.sv
test/ir_pulse_width_decoder_tb.sv
